[src/cbmr_pkg.sv]
// shared types and constants for the cartridge bank mapper with clock
// no dependencies
`default_nettype none

package cbmr_pkg;

  // input opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result targets
  localparam logic [2:0] TGT_NONE     = 3'd0;
  localparam logic [2:0] TGT_ROM_RD   = 3'd1;
  localparam logic [2:0] TGT_RAM_RD   = 3'd2;
  localparam logic [2:0] TGT_RAM_WR   = 3'd3;
  localparam logic [2:0] TGT_DATA     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
  localparam logic [1:0] CFG_RAM_BANK_COUNT = 2'd1;

  // clock register select codes
  localparam logic [3:0] RTC_SEC  = 4'h8;
  localparam logic [3:0] RTC_MIN  = 4'h9;
  localparam logic [3:0] RTC_HOUR = 4'hA;
  localparam logic [3:0] RTC_DAYL = 4'hB;
  localparam logic [3:0] RTC_DAYH = 4'hC;

  localparam int unsigned ROM_BANKS_MAX  = 128;
  localparam int unsigned RAM_BANK_BYTES = 8192;

  localparam logic [7:0] SECS_PER_MIN  = 8'd60;
  localparam logic [7:0] HOURS_PER_DAY = 8'd24;
  localparam logic [7:0] OPEN_BUS      = 8'hFF;

  // request to the shared remainder unit
  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } rem_req_t;

endpackage

`default_nettype wire

[src/cartridge_bank_mapper_rtc.sv]
// cartridge bank controller with real-time clock, top level
// depends on cbmr_pkg and cbmr_rem
`default_nettype none

// usage
//   input channel: opcode_i / address_i / write_value_i under in_valid_i and
//   in_stall_o; a request is taken when valid is high and stall is low
//   output channel: target_o / rom_address_o / ram_address_o / data_o under
//   out_valid_o and out_stall_i; exactly one result per request
//   config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is the rom bank count, index 1 the ram bank count, others ignored;
//   write only while the block is idle
// timing
//   reads, ticks and plain writes go from accept straight to the commit state
//   a rom bank write, and a seconds, minutes or hours write, runs the shared
//   remainder unit for 8 steps before the commit state
//   one request is in flight at a time; a finished result waits in the output
//   register while the next request is taken
// stall
//   while the receiver stalls, the result holds and the sequencer waits in its
//   commit state, so no state update or result is lost
// reset
//   asynchronous active low; rom bank 1, ram selected, clock at zero and
//   running, counts 2 and 0, output empty

module cartridge_bank_mapper_rtc (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input requests
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_value_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       target_o,
  output logic [20:0]      rom_address_o,
  output logic [14:0]      ram_address_o,
  output logic [7:0]       data_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import cbmr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MOD    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  localparam logic [7:0] BANKS_MAX = 8'(ROM_BANKS_MAX);
  localparam int unsigned RAM_OFS_W = $clog2(RAM_BANK_BYTES);

  logic [1:0] state_q, state_d;

  // captured request
  logic [1:0]  op_q;
  logic [15:0] addr_q;
  logic [7:0]  val_q;

  // configuration
  logic [7:0] rom_cnt_q;
  logic [4:0] ram_cnt_q;

  // mapper state
  logic [6:0] rom_bank_q, rom_bank_d;
  logic [1:0] ram_bank_q, ram_bank_d;
  logic       ram_sel_q, ram_sel_d;
  logic       clk_sel_q, clk_sel_d;
  logic [3:0] clk_reg_q, clk_reg_d;
  logic       ram_en_q, ram_en_d;
  logic [7:0] latch_last_q, latch_last_d;

  // live clock
  logic [5:0] sec_q, sec_d;
  logic [5:0] min_q, min_d;
  logic [4:0] hour_q, hour_d;
  logic [8:0] day_q, day_d;
  logic       halt_q, halt_d;
  logic       carry_q, carry_d;
  logic [27:0] latched_q, latched_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [2:0]  tgt_q, tgt_d;
  logic [20:0] rom_addr_q, rom_addr_d;
  logic [14:0] ram_addr_q, ram_addr_d;
  logic [7:0]  data_q, data_d;

  rem_req_t   rem_req;
  logic       rem_done;
  logic [7:0] rem_val;

  logic       accept;
  logic       out_free;
  logic       need_mod;
  logic       in_rom_sel, in_ram_area;
  logic [7:0] bank_cnt;
  logic [6:0] bank_req;

  logic       ram_area;
  logic       ram_ok;
  logic [7:0] clk_byte;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [9:0] day_inc;

  cbmr_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // decide at accept whether the remainder unit is needed
  always_comb begin
    in_rom_sel  = (address_i >= 16'h2000) && (address_i < 16'h4000);
    in_ram_area = (address_i >= 16'hA000) && (address_i < 16'hC000);
    // out of range counts fall back to the largest bank count
    if ((rom_cnt_q == 8'd0) || (rom_cnt_q > BANKS_MAX)) begin
      bank_cnt = BANKS_MAX;
    end else begin
      bank_cnt = rom_cnt_q;
    end
    bank_req = write_value_i[6:0];
    if (bank_req == 7'd0) begin
      bank_req = 7'd1;
    end
    need_mod = 1'b0;
    rem_req  = '0;
    if (opcode_i == OP_WRITE) begin
      if (in_rom_sel) begin
        need_mod         = 1'b1;
        rem_req.dividend = {1'b0, bank_req};
        rem_req.divisor  = bank_cnt;
      end else if (in_ram_area && ram_en_q && clk_sel_q &&
                   ((clk_reg_q == RTC_SEC) || (clk_reg_q == RTC_MIN) ||
                    (clk_reg_q == RTC_HOUR))) begin
        need_mod         = 1'b1;
        rem_req.dividend = write_value_i;
        rem_req.divisor  = (clk_reg_q == RTC_HOUR) ? HOURS_PER_DAY : SECS_PER_MIN;
      end
    end
    rem_req.start = accept && need_mod;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = need_mod ? ST_MOD : ST_COMMIT;
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // latched clock byte for the selected register
  always_comb begin
    case (clk_reg_q)
      RTC_SEC:  clk_byte = {2'b00, latched_q[5:0]};
      RTC_MIN:  clk_byte = {2'b00, latched_q[11:6]};
      RTC_HOUR: clk_byte = {3'b000, latched_q[16:12]};
      RTC_DAYL: clk_byte = latched_q[24:17];
      RTC_DAYH: clk_byte = {latched_q[27], latched_q[26], 5'b00000, latched_q[25]};
      default:  clk_byte = OPEN_BUS;
    endcase
  end

  // execute the captured request in the commit state
  always_comb begin
    rom_bank_d   = rom_bank_q;
    ram_bank_d   = ram_bank_q;
    ram_sel_d    = ram_sel_q;
    clk_sel_d    = clk_sel_q;
    clk_reg_d    = clk_reg_q;
    ram_en_d     = ram_en_q;
    latch_last_d = latch_last_q;
    sec_d        = sec_q;
    min_d        = min_q;
    hour_d       = hour_q;
    day_d        = day_q;
    halt_d       = halt_q;
    carry_d      = carry_q;
    latched_d    = latched_q;

    out_valid_d = out_valid_q && out_stall_i;
    tgt_d       = tgt_q;
    rom_addr_d  = rom_addr_q;
    ram_addr_d  = ram_addr_q;
    data_d      = data_q;

    ram_area = (addr_q >= 16'hA000) && (addr_q < 16'hC000);
    ram_ok   = ram_sel_q && ({3'b000, ram_bank_q} < ram_cnt_q);
    sec_inc  = {1'b0, sec_q} + 7'd1;
    min_inc  = {1'b0, min_q};
    hour_inc = {1'b0, hour_q};
    day_inc  = {1'b0, day_q};

    if ((state_q == ST_COMMIT) && out_free) begin
      out_valid_d = 1'b1;
      tgt_d       = TGT_NONE;
      rom_addr_d  = '0;
      ram_addr_d  = '0;
      data_d      = '0;
      case (op_q)
        OP_READ: begin
          if (addr_q < 16'h4000) begin
            tgt_d      = TGT_ROM_RD;
            rom_addr_d = {7'd0, addr_q[13:0]};
          end else if (addr_q < 16'h8000) begin
            tgt_d      = TGT_ROM_RD;
            rom_addr_d = {rom_bank_q, addr_q[13:0]};
          end else if (ram_area) begin
            tgt_d  = TGT_DATA;
            data_d = OPEN_BUS;
            if (ram_en_q) begin
              if (clk_sel_q) begin
                data_d = clk_byte;
              end else if (ram_ok) begin
                tgt_d      = TGT_RAM_RD;
                data_d     = '0;
                ram_addr_d = {ram_bank_q, addr_q[RAM_OFS_W-1:0]};
              end
            end
          end else begin
            tgt_d  = TGT_DATA;
            data_d = OPEN_BUS;
          end
        end
        OP_WRITE: begin
          if (addr_q < 16'h2000) begin
            ram_en_d = (val_q[3:0] == 4'hA);
          end else if (addr_q < 16'h4000) begin
            rom_bank_d = rem_val[6:0];
          end else if (addr_q < 16'h6000) begin
            if (val_q <= 8'h03) begin
              ram_bank_d = val_q[1:0];
              clk_sel_d  = 1'b0;
              ram_sel_d  = 1'b1;
            end else if ((val_q >= 8'h08) && (val_q <= 8'h0C)) begin
              clk_sel_d = 1'b1;
              ram_sel_d = 1'b0;
              clk_reg_d = val_q[3:0];
            end
          end else if (addr_q < 16'h8000) begin
            // latch on a zero then one sequence
            if ((latch_last_q == 8'd0) && (val_q == 8'd1)) begin
              latched_d = {carry_q, halt_q, day_q, hour_q, min_q, sec_q};
            end
            latch_last_d = val_q;
          end else if (ram_area && ram_en_q) begin
            if (clk_sel_q) begin
              case (clk_reg_q)
                RTC_SEC:  sec_d  = rem_val[5:0];
                RTC_MIN:  min_d  = rem_val[5:0];
                RTC_HOUR: hour_d = rem_val[4:0];
                RTC_DAYL: day_d  = {day_q[8], val_q};
                RTC_DAYH: begin
                  day_d   = {val_q[0], day_q[7:0]};
                  halt_d  = val_q[6];
                  carry_d = val_q[7];
                end
                default: ;
              endcase
            end else if (ram_ok) begin
              tgt_d      = TGT_RAM_WR;
              data_d     = val_q;
              ram_addr_d = {ram_bank_q, addr_q[RAM_OFS_W-1:0]};
            end
          end
        end
        OP_TICK: begin
          // a halted clock loses the tick
          if (!halt_q) begin
            if (sec_inc >= 7'(SECS_PER_MIN)) begin
              sec_inc = '0;
              min_inc = min_inc + 7'd1;
            end
            if (min_inc >= 7'(SECS_PER_MIN)) begin
              min_inc  = '0;
              hour_inc = hour_inc + 6'd1;
            end
            if (hour_inc >= 6'(HOURS_PER_DAY)) begin
              hour_inc = '0;
              day_inc  = day_inc + 10'd1;
              if (day_inc[9]) begin
                carry_d = 1'b1;
              end
            end
            sec_d  = sec_inc[5:0];
            min_d  = min_inc[5:0];
            hour_d = hour_inc[4:0];
            day_d  = day_inc[8:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rom_cnt_q    <= 8'd2;
      ram_cnt_q    <= 5'd0;
      rom_bank_q   <= 7'd1;
      ram_bank_q   <= 2'd0;
      ram_sel_q    <= 1'b1;
      clk_sel_q    <= 1'b0;
      clk_reg_q    <= 4'd0;
      ram_en_q     <= 1'b0;
      latch_last_q <= 8'd0;
      sec_q        <= 6'd0;
      min_q        <= 6'd0;
      hour_q       <= 5'd0;
      day_q        <= 9'd0;
      halt_q       <= 1'b0;
      carry_q      <= 1'b0;
      latched_q    <= 28'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rom_bank_q   <= rom_bank_d;
      ram_bank_q   <= ram_bank_d;
      ram_sel_q    <= ram_sel_d;
      clk_sel_q    <= clk_sel_d;
      clk_reg_q    <= clk_reg_d;
      ram_en_q     <= ram_en_d;
      latch_last_q <= latch_last_d;
      sec_q        <= sec_d;
      min_q        <= min_d;
      hour_q       <= hour_d;
      day_q        <= day_d;
      halt_q       <= halt_d;
      carry_q      <= carry_d;
      latched_q    <= latched_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ROM_BANK_COUNT) begin
          rom_cnt_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_RAM_BANK_COUNT) begin
          ram_cnt_q <= cfg_data_i[4:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      addr_q <= address_i;
      val_q  <= write_value_i;
    end
    tgt_q      <= tgt_d;
    rom_addr_q <= rom_addr_d;
    ram_addr_q <= ram_addr_d;
    data_q     <= data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = tgt_q;
  assign rom_address_o = rom_addr_q;
  assign ram_address_o = ram_addr_q;
  assign data_o        = data_q;

endmodule

`default_nettype wire

[src/cbmr_rem.sv]
// shared iterative remainder unit, one restoring step per cycle
// depends on cbmr_pkg
`default_nettype none

module cbmr_rem (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cbmr_pkg::rem_req_t req_i,
  output logic                  done_o,
  output logic [7:0]            rem_o
);
  import cbmr_pkg::*;

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] dvd_q, dvd_d;
  logic [7:0] div_q, div_d;
  logic [7:0] rem_q, rem_d;
  logic [8:0] trial;

  // divisor is at least 1 and the remainder stays below it
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[7]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = 8'd0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = 8'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[7:0];
      end
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
